/* hw/rtl/trrq_pkg.sv */
// Package with payload types and constants for the triangle radius ratio quality unit.
package trrq_pkg;

  localparam int unsigned MaxTriangles = 1048575;
  localparam int CoordW = 16;
  localparam int SqW = 35;
  localparam int LenW = 25;
  localparam int FacW = 27;
  localparam int NumW = 75;
  localparam int DenW = 78;
  localparam int RatioW = 32;
  localparam int SumW = 52;
  localparam int CountW = 20;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic                     final_triangle;
  } tri_in_t;

  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic              degenerate;
    logic [RatioW-1:0] mean_ratio;
    logic              mean_valid;
  } tri_out_t;

endpackage

/* hw/rtl/trrq_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
module trrq_divider #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  localparam int RW = DW + QW;

  logic [QW:0]         vld;
  logic [QW:0][RW-1:0] rem;
  logic [QW:0][DW-1:0] dv;
  logic [QW:0][QW-1:0] q;
  logic [QW:0][TW-1:0] tg;

  always_comb begin
    vld[0] = in_valid;
    rem[0] = RW'(num);
    dv[0]  = den;
    q[0]   = '0;
    tg[0]  = tag;
  end

  // Stage k decides quotient bit QW-1-k.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] shifted;
    logic          take;
    assign shifted = RW'({dv[k], {QW{1'b0}}} >> (k + 1));
    assign take    = rem[k] >= shifted;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1] <= take ? rem[k] - shifted : rem[k];
        q[k+1]   <= q[k] | (take ? QW'(1) << (QW - 1 - k) : QW'(0));
        dv[k+1]  <= dv[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign out_tag   = tg[QW];

endmodule

/* hw/rtl/triangle_radius_ratio_quality_unit.sv */
// Triangle radius ratio quality unit: edge lengths, ratio, running mean.
// Throughput: one triangle per cycle; the pipeline stalls as a whole when out is held.
// Square roots take one bit per stage; the ratio and mean divides one bit per stage.
// Reset clears all valid bits, the running sum and the count; data registers are not reset.
module triangle_radius_ratio_quality_unit #(
  parameter int unsigned MAX_TRIANGLES = trrq_pkg::MaxTriangles
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trrq_pkg::tri_in_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output trrq_pkg::tri_out_t out_data
);

  localparam int LenW = trrq_pkg::LenW;
  localparam int SqW  = trrq_pkg::SqW;
  localparam int FacW = trrq_pkg::FacW;
  localparam int FtW  = trrq_pkg::FacW - 1; // a positive factor can reach twice an edge length
  localparam int NumW = trrq_pkg::NumW;
  localparam int DenW = trrq_pkg::DenW;
  localparam int RW   = trrq_pkg::RatioW;
  localparam int SumW = trrq_pkg::SumW;
  localparam int CntW = trrq_pkg::CountW;
  localparam int RootW = 2 * LenW + 2; // radicand width after the 16-bit shift, padded even

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: coordinate differences.
  logic s1_v, s1_f;
  logic signed [16:0] s1_d [0:2][0:2];
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
    if (en) begin
      s1_f <= in_data.final_triangle;
      s1_d[0][0] <= 17'(in_data.bx) - 17'(in_data.ax);
      s1_d[0][1] <= 17'(in_data.by) - 17'(in_data.ay);
      s1_d[0][2] <= 17'(in_data.bz) - 17'(in_data.az);
      s1_d[1][0] <= 17'(in_data.cx) - 17'(in_data.bx);
      s1_d[1][1] <= 17'(in_data.cy) - 17'(in_data.by);
      s1_d[1][2] <= 17'(in_data.cz) - 17'(in_data.bz);
      s1_d[2][0] <= 17'(in_data.ax) - 17'(in_data.cx);
      s1_d[2][1] <= 17'(in_data.ay) - 17'(in_data.cy);
      s1_d[2][2] <= 17'(in_data.az) - 17'(in_data.cz);
    end
  end

  // Stage 2: squares.
  logic s2_v, s2_f;
  logic [33:0] s2_p [0:2][0:2];
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      s2_f <= s1_f;
      for (int e = 0; e < 3; e++) begin
        for (int i = 0; i < 3; i++) begin
          s2_p[e][i] <= 34'(s1_d[e][i] * s1_d[e][i]);
        end
      end
    end
  end

  // Stage 3: squared lengths.
  logic s3_v, s3_f;
  logic [SqW-1:0] s3_sq [0:2];
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
    if (en) begin
      s3_f <= s2_f;
      for (int e = 0; e < 3; e++) begin
        s3_sq[e] <= SqW'(s2_p[e][0]) + SqW'(s2_p[e][1]) + SqW'(s2_p[e][2]);
      end
    end
  end

  // Square root pipeline: one result bit per stage, three lanes.
  logic [LenW:0] rv;
  logic [LenW:0] rf;
  logic [RootW-1:0] rrem [0:LenW][0:2];
  logic [LenW-1:0]  rres [0:LenW][0:2];
  always_comb begin
    rv[0] = s3_v;
    rf[0] = s3_f;
    for (int e = 0; e < 3; e++) begin
      rrem[0][e] = RootW'({s3_sq[e], 16'h0000});
      rres[0][e] = '0;
    end
  end
  for (genvar k = 0; k < LenW; k++) begin : g_sqrt
    localparam int Bit = LenW - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (en) rv[k+1] <= rv[k];
      if (en) begin
        rf[k+1] <= rf[k];
        for (int e = 0; e < 3; e++) begin
          logic [RootW-1:0] trial;
          trial = (RootW'(rres[k][e]) << (Bit + 1)) + (RootW'(1) << (2 * Bit));
          if (rrem[k][e] >= trial) begin
            rrem[k+1][e] <= rrem[k][e] - trial;
            rres[k+1][e] <= rres[k][e] | (LenW'(1) << Bit);
          end else begin
            rrem[k+1][e] <= rrem[k][e];
            rres[k+1][e] <= rres[k][e];
          end
        end
      end
    end
  end

  // Stage A: factors and ab.
  logic ta_v, ta_f, ta_dg;
  logic signed [FacW-1:0] ta_t [0:2];
  logic [2*LenW-1:0] ta_ab;
  logic [LenW-1:0]   ta_c;
  always_comb begin
    logic [LenW-1:0] a, b, c;
    a = rres[LenW][0];
    b = rres[LenW][1];
    c = rres[LenW][2];
    ta_t[0] = FacW'(b) + FacW'(c) - FacW'(a);
    ta_t[1] = FacW'(c) + FacW'(a) - FacW'(b);
    ta_t[2] = FacW'(a) + FacW'(b) - FacW'(c);
  end
  logic [FtW-1:0] tb_t [0:2];
  logic tb_v, tb_f, tb_dg;
  always_ff @(posedge clk) begin
    if (rst) tb_v <= 1'b0;
    else if (en) tb_v <= rv[LenW];
    if (en) begin
      tb_f  <= rf[LenW];
      tb_dg <= (ta_t[0] <= 0) || (ta_t[1] <= 0) || (ta_t[2] <= 0);
      for (int e = 0; e < 3; e++) tb_t[e] <= FtW'(ta_t[e]);
      ta_ab <= (2*LenW)'(rres[LenW][0]) * (2*LenW)'(rres[LenW][1]);
      ta_c  <= rres[LenW][2];
    end
  end
  assign ta_v = tb_v;
  assign ta_f = tb_f;
  assign ta_dg = tb_dg;

  // Stage B: abc and t1*t2 (products of 50x25 bits are cut in two 25-bit halves).
  logic tc_v, tc_f, tc_dg;
  logic [2*LenW-1:0] tc_ablo_c, tc_abhi_c;
  logic [2*FtW-1:0]  tc_t12;
  logic [FtW-1:0]    tc_t3;
  always_ff @(posedge clk) begin
    if (rst) tc_v <= 1'b0;
    else if (en) tc_v <= ta_v;
    if (en) begin
      tc_f  <= ta_f;
      tc_dg <= ta_dg;
      tc_ablo_c <= (2*LenW)'(ta_ab[LenW-1:0]) * (2*LenW)'(ta_c);
      tc_abhi_c <= (2*LenW)'(ta_ab[2*LenW-1:LenW]) * (2*LenW)'(ta_c);
      tc_t12 <= (2*FtW)'(tb_t[0]) * (2*FtW)'(tb_t[1]);
      tc_t3  <= tb_t[2];
    end
  end

  // Stage C: combine abc, split den multiply.
  logic td_v, td_f, td_dg;
  logic [NumW-1:0] td_abc;
  logic [2*FtW-1:0] td_lo, td_hi;
  always_ff @(posedge clk) begin
    if (rst) td_v <= 1'b0;
    else if (en) td_v <= tc_v;
    if (en) begin
      td_f  <= tc_f;
      td_dg <= tc_dg;
      td_abc <= NumW'(tc_ablo_c) + (NumW'(tc_abhi_c) << LenW);
      td_lo <= (2*FtW)'(tc_t12[FtW-1:0]) * (2*FtW)'(tc_t3);
      td_hi <= (2*FtW)'(tc_t12[2*FtW-1:FtW]) * (2*FtW)'(tc_t3);
    end
  end

  // Stage D: final den, numerator, saturation check.
  logic te_v, te_f, te_dg, te_sat;
  logic [DenW+RW-1:0] te_num;
  logic [DenW-1:0]    te_den;
  always_ff @(posedge clk) begin
    logic [DenW-1:0] den;
    logic [DenW+RW-1:0] num;
    den = DenW'(td_lo) + (DenW'(td_hi) << FtW);
    num = (DenW+RW)'(td_abc) << 16;
    if (rst) te_v <= 1'b0;
    else if (en) te_v <= td_v;
    if (en) begin
      te_f   <= td_f;
      te_dg  <= td_dg;
      te_num <= num;
      te_den <= den;
      te_sat <= td_dg || (num >= ((DenW+RW)'(den) << RW));
    end
  end

  logic dq_v;
  logic [RW-1:0] dq_q;
  logic [2:0] dq_tag;
  trrq_divider #(.NW(DenW+RW), .DW(DenW), .QW(RW), .TW(3)) u_ratio_div (
    .clk, .rst, .en,
    .in_valid (te_v),
    .num      (te_num),
    .den      (te_den),
    .tag      ({te_f, te_dg, te_sat}),
    .out_valid(dq_v),
    .quo      (dq_q),
    .out_tag  (dq_tag)
  );

  // Accumulator stage: runs in order, one triangle per cycle while the pipeline is not stalled.
  logic [SumW-1:0] ratio_sum, sum_next;
  logic [CntW-1:0] triangle_count, count_next;
  logic [RW-1:0]   ratio_val;
  logic am_v, am_f, am_dg;
  logic [RW-1:0]   am_ratio;
  logic [SumW-1:0] am_sum;
  logic [CntW-1:0] am_cnt;
  assign ratio_val = dq_tag[0] ? '1 : dq_q;
  always_comb begin
    sum_next   = ratio_sum;
    count_next = triangle_count;
    if (triangle_count < CntW'(MAX_TRIANGLES)) begin
      sum_next   = ratio_sum + SumW'(ratio_val);
      count_next = triangle_count + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      am_v <= 1'b0;
      ratio_sum <= '0;
      triangle_count <= '0;
    end else if (en) begin
      am_v <= dq_v;
      if (dq_v) begin
        if (dq_tag[2]) begin
          ratio_sum <= '0;
          triangle_count <= '0;
        end else begin
          ratio_sum <= sum_next;
          triangle_count <= count_next;
        end
      end
    end
    if (en) begin
      am_f <= dq_tag[2];
      am_dg <= dq_tag[1];
      am_ratio <= ratio_val;
      am_sum <= sum_next;
      am_cnt <= (count_next == '0) ? CntW'(1) : count_next;
    end
  end

  logic mq_v;
  logic [SumW-1:0] mq_q;
  logic [RW+1:0]   mq_tag;
  trrq_divider #(.NW(SumW), .DW(CntW), .QW(SumW), .TW(RW+2)) u_mean_div (
    .clk, .rst, .en,
    .in_valid (am_v),
    .num      (am_f ? am_sum : SumW'(0)),
    .den      (am_cnt),
    .tag      ({am_ratio, am_dg, am_f}),
    .out_valid(mq_v),
    .quo      (mq_q),
    .out_tag  (mq_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= mq_v;
    if (en) begin
      out_data.ratio      <= mq_tag[RW+1:2];
      out_data.degenerate <= mq_tag[1];
      out_data.mean_valid <= mq_tag[0];
      out_data.mean_ratio <= mq_q[RW-1:0];
    end
  end

  a_deg_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.ratio == '1)
    else $error("degenerate result without saturated ratio");
  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.mean_valid |-> out_data.mean_ratio == '0)
    else $error("mean given without final triangle");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    en && dq_v && dq_tag[2] |=> ratio_sum == '0 && triangle_count == '0)
    else $error("sum not cleared after final triangle");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    triangle_count <= CntW'(MAX_TRIANGLES))
    else $error("count past limit");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the triangle radius ratio quality unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int Latency = 118;
  localparam int WatchLimit = 20000;
  localparam int InBits = $bits(trrq_pkg::tri_in_t);

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  trrq_pkg::tri_in_t  in_data;
  logic               out_valid;
  logic               out_ready;
  trrq_pkg::tri_out_t out_data;

  triangle_radius_ratio_quality_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: running sum and triangle count of the mesh in progress.
  logic [trrq_pkg::SumW-1:0]   mesh_sum;
  logic [trrq_pkg::CountW-1:0] mesh_count;
  trrq_pkg::tri_out_t          expected_q[$];
  int                          error_count = 0;
  int                          idle_cycles;
  bit                          gaps_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [trrq_pkg::LenW-1:0] edge_length(
      logic signed [trrq_pkg::CoordW-1:0] px,
      logic signed [trrq_pkg::CoordW-1:0] py, logic signed [trrq_pkg::CoordW-1:0] pz,
      logic signed [trrq_pkg::CoordW-1:0] qx, logic signed [trrq_pkg::CoordW-1:0] qy,
      logic signed [trrq_pkg::CoordW-1:0] qz);
    longint dx, dy, dz;
    logic [63:0] sq, root, trial;
    dx = longint'(qx) - longint'(px);
    dy = longint'(qy) - longint'(py);
    dz = longint'(qz) - longint'(pz);
    sq = 64'(dx * dx + dy * dy + dz * dz) << 16;
    // Bitwise integer square root, floor.
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= sq) root = trial;
    end
    return root[trrq_pkg::LenW-1:0];
  endfunction

  function automatic trrq_pkg::tri_out_t measure_triangle(trrq_pkg::tri_in_t t);
    trrq_pkg::tri_out_t r;
    logic [trrq_pkg::LenW-1:0] la, lb, lc;
    longint f1, f2, f3;
    logic [159:0] num, den;
    la = edge_length(t.ax, t.ay, t.az, t.bx, t.by, t.bz);
    lb = edge_length(t.bx, t.by, t.bz, t.cx, t.cy, t.cz);
    lc = edge_length(t.cx, t.cy, t.cz, t.ax, t.ay, t.az);
    f1 = longint'(lb) + longint'(lc) - longint'(la);
    f2 = longint'(lc) + longint'(la) - longint'(lb);
    f3 = longint'(la) + longint'(lb) - longint'(lc);
    r = '0;
    r.ratio = '1;
    if (f1 <= 0 || f2 <= 0 || f3 <= 0) begin
      r.degenerate = 1'b1;
    end else begin
      num = (160'(la) * 160'(lb) * 160'(lc)) << 16;
      den = 160'(f1) * 160'(f2) * 160'(f3);
      if (num < (den << 32)) r.ratio = 32'(num / den);
    end
    if (mesh_count < trrq_pkg::CountW'(trrq_pkg::MaxTriangles)) begin
      mesh_sum = mesh_sum + trrq_pkg::SumW'(r.ratio);
      mesh_count++;
    end
    if (t.final_triangle) begin
      r.mean_ratio = 32'(mesh_sum / mesh_count);
      r.mean_valid = 1'b1;
      mesh_sum = '0;
      mesh_count = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.ratio), 32'd0);
      end else begin
        trrq_pkg::tri_out_t want;
        want = expected_q.pop_front();
        if (out_data.ratio !== want.ratio)
          report_mismatch("ratio", out_data.ratio, want.ratio);
        if (out_data.degenerate !== want.degenerate)
          report_mismatch("degenerate", 32'(out_data.degenerate), 32'(want.degenerate));
        if (out_data.mean_ratio !== want.mean_ratio)
          report_mismatch("mean_ratio", out_data.mean_ratio, want.mean_ratio);
        if (out_data.mean_valid !== want.mean_valid)
          report_mismatch("mean_valid", 32'(out_data.mean_valid), 32'(want.mean_valid));
      end
    end
  end

  // Receiver stalls in bursts.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_triangle(trrq_pkg::tri_in_t t);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(measure_triangle(t));
  endtask

  // The wait keeps the next send out of the same time step.
  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic trrq_pkg::tri_in_t make_tri(int x0, int y0, int z0,
      int x1, int y1, int z1, int x2, int y2, int z2, bit last);
    trrq_pkg::tri_in_t t;
    t.ax = 16'(x0); t.ay = 16'(y0); t.az = 16'(z0);
    t.bx = 16'(x1); t.by = 16'(y1); t.bz = 16'(z1);
    t.cx = 16'(x2); t.cy = 16'(y2); t.cz = 16'(z2);
    t.final_triangle = last;
    return t;
  endfunction

  function automatic trrq_pkg::tri_in_t random_tri(int span, bit last);
    trrq_pkg::tri_in_t t;
    int bx, by, bz;
    t = trrq_pkg::tri_in_t'(InBits'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (span < 32768) begin
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      bz = $urandom_range(0, 65535) - 32768;
      t = make_tri(bx, by, bz,
          bx + $urandom_range(0, 2 * span) - span, by + $urandom_range(0, 2 * span) - span,
          bz + $urandom_range(0, 2 * span) - span,
          bx + $urandom_range(0, 2 * span) - span, by + $urandom_range(0, 2 * span) - span,
          bz + $urandom_range(0, 2 * span) - span, 0);
    end
    t.final_triangle = last;
    return t;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 128, 222, 0, 0));     // near equilateral
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));           // coincident
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 512, 0, 0, 0));       // collinear
    send_triangle(make_tri(0, 0, 0, 25600, 0, 0, 12800, 1, 0, 0));   // huge ratio
    send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, -32768, 0, 0));
    send_triangle(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
                           -32768, -32768, 32767, 0));
    send_triangle(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 1));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));           // one-item mesh
    send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));           // degenerate mean
    send_triangle(make_tri(100, -200, 300, -400, 500, -600, 700, 800, -900, 1));
    release_input();
  endtask

  task automatic test_random_meshes(int items);
    int left, mesh_len;
    int span;
    left = items;
    while (left > 0) begin
      mesh_len = $urandom_range(1, 40);
      for (int i = 0; i < mesh_len && left > 0; i++) begin
        case ($urandom_range(0, 3))
          0: span = 32768;
          1: span = $urandom_range(1, 8);
          2: span = $urandom_range(1, 600);
          default: span = $urandom_range(1, 20000);
        endcase
        send_triangle(random_tri(span, (i == mesh_len - 1) || left == 1));
        left--;
      end
    end
    release_input();
  endtask

  task automatic test_drain_pause();
    send_triangle(random_tri(300, 0));
    release_input();
    wait_drained();
    send_triangle(random_tri(300, 1));
    release_input();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mesh_sum = '0;
    mesh_count = '0;
    gaps_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random_meshes(1300);
    gaps_on = 1'b0;
    test_random_meshes(330);
    wait_drained();
    repeat (Latency + 20) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
